>>> rtl/hhd_pkg.sv
// ----------------------------------------------------------------------------
// hhd_pkg
// Types, code tables and the elaborated code trie of the HPACK static
// Huffman code.
// ----------------------------------------------------------------------------
package hhd_pkg;

  localparam int SYM_COUNT    = 256;
  localparam int NODE_COUNT   = 256;
  localparam int MAX_PAD_BITS = 7;

  typedef enum logic [1:0] {
    OUT_SYMBOL = 2'd0,
    OUT_OK     = 2'd1,
    OUT_ERR    = 2'd2
  } hhd_outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_END
  } hhd_state_t;

  // raw trie entry: [8] leaf, [7:0] symbol or child node; all zero = no path
  typedef logic [8:0] hhd_raw_ent_t;
  typedef logic [NODE_COUNT-1:0][1:0][8:0] hhd_tree_t;

  typedef struct packed {
    logic       hit;
    logic       leaf;
    logic [7:0] val;
  } hhd_ent_t;

  localparam logic [29:0] CODE_BITS [SYM_COUNT] = '{
    30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,
    30'hfffffe7,30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,
    30'hfffffeb,30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,
    30'hffffff2,30'h3ffffffe,30'hffffff3,30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,
    30'hffffff8,30'hffffff9,30'hffffffa,30'hffffffb,
    30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,30'h3fa,30'h3fb,30'hf9,
    30'h7fb,30'hfa,30'h16,30'h17,30'h18,
    30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,30'h1e,30'h1f,30'h5c,30'hfb,
    30'h7ffc,30'h20,30'hffb,30'h3fc,
    30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,30'h63,30'h64,30'h65,30'h66,
    30'h67,30'h68,30'h69,30'h6a,
    30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,30'hfc,30'h73,30'hfd,30'h1ffb,
    30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
    30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,30'h27,30'h6,30'h74,30'h75,
    30'h28,30'h29,30'h2a,30'h7,
    30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,30'h79,30'h7a,30'h7b,30'h7ffe,
    30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
    30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
    30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
    30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
    30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
    30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
    30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
    30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
    30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
    30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
    30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
    30'h1ffffed,
    30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,
    30'hfffff2,
    30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
    30'h7ffffe5,
    30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
    30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,
    30'h7ffff4,
    30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
    30'h7ffffea,
    30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,
    30'h3ffffee
  };

  localparam logic [4:0] CODE_LEN [SYM_COUNT] = '{
    5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,
    5'd28,5'd28,
    5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
    5'd28,5'd28,
    5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
    5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
    5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
    5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
    5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
    5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,
    5'd24,5'd23,
    5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,
    5'd23,5'd24,
    5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,
    5'd23,5'd23,
    5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,
    5'd22,5'd23,
    5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,
    5'd24,5'd25,
    5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,
    5'd27,5'd27,
    5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,
    5'd26,5'd23,
    5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,
    5'd27,5'd26
  };

  function automatic hhd_tree_t build_tree();
    hhd_tree_t    t;
    int           used;
    int           node;
    int           len;
    int           s;
    int           i;
    logic [29:0]  code;
    logic         b;
    hhd_raw_ent_t c;
    logic         ok;
    t    = '0;
    used = 1;
    for (s = 0; s < SYM_COUNT; s++) begin
      len  = int'(CODE_LEN[s]);
      code = CODE_BITS[s];
      node = 0;
      ok   = 1'b1;
      for (i = len; i > 1; i--) begin
        if (ok) begin
          b = code[i-1];
          c = t[node][b];
          if (c == '0) begin
            if (used >= NODE_COUNT) begin
              ok = 1'b0;
            end else begin
              t[node][b] = {1'b0, 8'(used)};
              node       = used;
              used       = used + 1;
            end
          end else if (c[8]) begin
            ok = 1'b0;
          end else begin
            node = int'(c[7:0]);
          end
        end
      end
      if (ok && len > 0 && t[node][code[0]] == '0) begin
        t[node][code[0]] = {1'b1, 8'(s)};
      end
    end
    return t;
  endfunction

  localparam hhd_tree_t TRIE = build_tree();

endpackage

>>> rtl/hhd_if.sv
// ----------------------------------------------------------------------------
// hhd_if
// Valid/ready channels for coded bytes and decoded results.
// ----------------------------------------------------------------------------
interface hhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;
  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface hhd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] outcome;
  logic       run_end;
  modport source (output valid, output symbol, output outcome, output run_end, input ready);
  modport sink   (input valid, input symbol, input outcome, input run_end, output ready);
endinterface

>>> rtl/hhd_trie_rom.sv
// ----------------------------------------------------------------------------
// hhd_trie_rom
// Code trie lookup: child entry of a node for one code bit.
// ----------------------------------------------------------------------------
module hhd_trie_rom
  import hhd_pkg::*;
(
  input  logic [7:0] node,
  input  logic       bit_in,
  output hhd_ent_t   ent
);

  hhd_raw_ent_t raw;

  assign raw      = TRIE[node][bit_in];
  assign ent.hit  = (raw != '0);
  assign ent.leaf = raw[8];
  assign ent.val  = raw[7:0];

endmodule

>>> rtl/hpack_huffman_string_decoder.sv
// A byte walks the trie one bit per cycle unless back-pressure stalls it;
// its last symbol is presented after the walk, and a string end result
// follows when it ends the string. A new coded byte is taken only once the
// last is done; an unused path ends a walk early, an error skips later walks.
// Reset: synchronous active-low rst_n returns the walk to the root node and
// clears pending-bit and error state.
// ----------------------------------------------------------------------------
// hpack_huffman_string_decoder
// Bit-serial HPACK Huffman string decoder with padding and error checks.
// ----------------------------------------------------------------------------
module hpack_huffman_string_decoder
  import hhd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hhd_in_if.sink     in_ch,
  hhd_out_if.source  out_ch
);

  hhd_state_t  state_r, state_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        final_r, final_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  node_r, node_nxt;
  logic [4:0]  pend_cnt_r, pend_cnt_nxt;
  logic        all_ones_r, all_ones_nxt;
  logic        failed_r, failed_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic [7:0]  hold_sym_r, hold_sym_nxt;
  logic        out_v_r, out_v_nxt;
  logic [7:0]  out_sym_r, out_sym_nxt;
  logic [1:0]  out_oc_r, out_oc_nxt;
  logic        out_end_r, out_end_nxt;

  hhd_ent_t    ent;
  logic        cur_bit;
  logic        out_free;
  logic        stall;
  logic        accept;

  assign cur_bit  = byte_r[bit_idx_r];
  assign out_free = !out_v_r || out_ch.ready;
  assign stall    = ent.hit && ent.leaf && hold_v_r && !out_free;
  assign accept   = in_ch.valid && in_ch.ready;

  hhd_trie_rom u_rom (
    .node   (node_r),
    .bit_in (cur_bit),
    .ent    (ent)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = failed_r ? ST_FLUSH : ST_WALK;
      end
      ST_WALK: begin
        if (!stall && (!ent.hit || bit_idx_r == 3'd0)) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!hold_v_r || out_free) state_nxt = final_r ? ST_END : ST_IDLE;
      end
      ST_END: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    byte_nxt     = byte_r;
    final_nxt    = final_r;
    bit_idx_nxt  = bit_idx_r;
    node_nxt     = node_r;
    pend_cnt_nxt = pend_cnt_r;
    all_ones_nxt = all_ones_r;
    failed_nxt   = failed_r;
    hold_v_nxt   = hold_v_r;
    hold_sym_nxt = hold_sym_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_sym_nxt  = out_sym_r;
    out_oc_nxt   = out_oc_r;
    out_end_nxt  = out_end_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          byte_nxt    = in_ch.code_byte;
          final_nxt   = in_ch.final_byte;
          bit_idx_nxt = 3'd7;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          bit_idx_nxt = bit_idx_r - 3'd1;
          if (!ent.hit) begin
            failed_nxt = 1'b1;
          end else if (ent.leaf) begin
            if (hold_v_r) begin
              out_v_nxt   = 1'b1;
              out_sym_nxt = hold_sym_r;
              out_oc_nxt  = OUT_SYMBOL;
              out_end_nxt = 1'b0;
            end
            hold_v_nxt   = 1'b1;
            hold_sym_nxt = ent.val;
            node_nxt     = '0;
            pend_cnt_nxt = '0;
            all_ones_nxt = 1'b1;
          end else begin
            node_nxt     = ent.val;
            pend_cnt_nxt = pend_cnt_r + 5'd1;
            all_ones_nxt = all_ones_r & cur_bit;
          end
        end
      end
      ST_FLUSH: begin
        if (hold_v_r && out_free) begin
          out_v_nxt   = 1'b1;
          out_sym_nxt = hold_sym_r;
          out_oc_nxt  = OUT_SYMBOL;
          out_end_nxt = !final_r;
          hold_v_nxt  = 1'b0;
        end
      end
      ST_END: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_sym_nxt  = '0;
          out_oc_nxt   = (failed_r || pend_cnt_r > 5'(MAX_PAD_BITS) || !all_ones_r)
                         ? OUT_ERR : OUT_OK;
          out_end_nxt  = 1'b1;
          node_nxt     = '0;
          pend_cnt_nxt = '0;
          all_ones_nxt = 1'b1;
          failed_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      node_r     <= '0;
      pend_cnt_r <= '0;
      all_ones_r <= 1'b1;
      failed_r   <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      node_r     <= node_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      all_ones_r <= all_ones_nxt;
      failed_r   <= failed_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    final_r    <= final_nxt;
    bit_idx_r  <= bit_idx_nxt;
    hold_sym_r <= hold_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_oc_r   <= out_oc_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_v_r;
  assign out_ch.symbol  = out_sym_r;
  assign out_ch.outcome = out_oc_r;
  assign out_ch.run_end = out_end_r;

endmodule
